@@ rtl/core/atp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_pkg
// Shared types and constants for the AT modem response parser.
// ----------------------------------------------------------------------------
package atp_pkg;

    localparam int unsigned PAYLOAD_LEN_W = 16;

    // Verdict codes carried on the result channel
    localparam logic [2:0] VERDICT_NONE    = 3'd0;
    localparam logic [2:0] VERDICT_PROMPT  = 3'd1;
    localparam logic [2:0] VERDICT_OK      = 3'd2;
    localparam logic [2:0] VERDICT_CONNECT = 3'd3;
    localparam logic [2:0] VERDICT_CLOSED  = 3'd4;
    localparam logic [2:0] VERDICT_DATA    = 3'd5;

    // Characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_O     = 8'h4F;

    localparam logic [7:0] WORD_CONNECT [7] = '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54};
    localparam logic [7:0] WORD_CLOSED  [6] = '{8'h43, 8'h4C, 8'h4F, 8'h53, 8'h45, 8'h44};
    localparam logic [7:0] IPD_HEAD     [5] = '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic                     is_verdict;
        logic [7:0]               payload_byte;
        logic [2:0]               verdict;
        logic [7:0]               client_number;
        logic [PAYLOAD_LEN_W-1:0] payload_length;
        logic                     payload_short;
    } t_out_item;

endpackage

@@ rtl/core/at_modem_response_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_modem_response_parser
// Byte-serial classifier of modem responses (prompt, OK, CONNECT, CLOSED, +IPD).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one response
//   byte per transaction; end_of_buffer marks the last byte of a buffer.
//   Output channel (o_out_valid / i_out_stall / o_out_data) gives payload
//   bytes of a +IPD message as they pass (is_verdict = 0) and one verdict
//   per buffer on its last byte (is_verdict = 1), payload byte first.
//   Each byte is parsed in the cycle it is accepted; its results are written
//   into a four-entry output queue register and leave it in order.
//   Throughput is one byte per cycle while the input is not stalled; a last
//   byte that also carries payload yields two results, sent one at a time.
//   Input stalls whenever fewer than two queue entries are free, so a
//   stalled receiver backs up into the input once the queue fills.
//   Reset (synchronous, active low) empties the queue and returns the parser
//   to skipping leading line breaks; after each verdict the parser returns
//   to the same state on its own.
// ----------------------------------------------------------------------------
module at_modem_response_parser
    import atp_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int unsigned LW = LENGTH_BITS + 4;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    typedef enum logic [3:0] {
        PH_SKIP       = 4'd0,
        PH_OK         = 4'd1,
        PH_ID         = 4'd2,
        PH_WORD       = 4'd3,
        PH_IPD        = 4'd4,
        PH_IPD_ID     = 4'd5,
        PH_IPD_LEN    = 4'd6,
        PH_PAYLOAD    = 4'd7,
        PH_OK_DONE    = 4'd8,
        PH_CONN_DONE  = 4'd9,
        PH_CLOSE_DONE = 4'd10,
        PH_FAIL       = 4'd11,
        PH_DATA_DONE  = 4'd12
    } t_phase;

    function automatic logic [7:0] add_id(input logic [7:0] acc, input logic [7:0] b);
        logic [11:0] v;
        v = 12'(acc) * 12'd10 + 12'(b[3:0]);
        return (v > 12'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] add_len(input logic [LENGTH_BITS-1:0] acc,
                                                       input logic [7:0] b);
        logic [LW-1:0] v;
        v = LW'(acc) * LW'(10) + LW'(b[3:0]);
        return (v > LW'(LEN_MAX)) ? LEN_MAX : v[LENGTH_BITS-1:0];
    endfunction

    // Parser state
    t_phase                 r_phase, n_phase;
    logic [7:0]             r_id, n_id;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic                   r_prompt, n_prompt;
    logic [3:0]             r_pos, n_pos;
    logic [1:0]             r_live, n_live;   // bit 0 CONNECT, bit 1 CLOSED
    logic                   r_ended, n_ended;

    // Output queue
    t_out_item  r_q [4];
    logic [1:0] r_head, n_head;
    logic [1:0] r_tail, n_tail;
    logic [2:0] r_count, n_count;

    logic       w_accept, w_pop;
    logic [7:0] w_b;
    logic       w_last, w_is_digit;
    logic [1:0] w_push;
    t_out_item  w_res_a, w_res_b, w_pay, w_verd;
    logic       w_has_pay;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_pop      = o_out_valid && !i_out_stall;
    assign w_b        = i_in_data.byte_in;
    assign w_last     = i_in_data.end_of_buffer;
    assign w_is_digit = (w_b >= CH_ZERO) && (w_b <= CH_NINE);

    assign o_in_stall  = r_count > 3'd2;
    assign o_out_valid = r_count != 3'd0;
    assign o_out_data  = r_q[r_head];

    always_comb begin
        n_phase  = r_phase;
        n_id     = r_id;
        n_len    = r_len;
        n_rem    = r_rem;
        n_prompt = r_prompt;
        n_pos    = r_pos;
        n_live   = r_live;
        n_ended  = r_ended;
        w_has_pay = 1'b0;
        w_pay     = '0;
        w_verd    = '0;

        if (r_phase == PH_PAYLOAD) begin
            if (!r_ended && w_b == CH_GT) n_prompt = 1'b1;
            if (w_b == CH_NUL) n_ended = 1'b1;
            w_has_pay          = 1'b1;
            w_pay.payload_byte = w_b;
            if (r_rem != '0) n_rem = r_rem - 1'b1;
            if (n_rem == '0) n_phase = PH_DATA_DONE;
        end else if (!r_ended) begin
            if (w_b == CH_GT) n_prompt = 1'b1;
            if (w_b == CH_NUL) begin
                n_ended = 1'b1;
                if (r_phase < PH_PAYLOAD) n_phase = PH_FAIL;
            end else begin
                case (r_phase)
                    PH_SKIP: begin
                        if (w_b == CH_CR || w_b == CH_LF) begin
                            n_phase = PH_SKIP;
                        end else if (w_b == CH_O) begin
                            n_phase = PH_OK;
                        end else if (w_is_digit) begin
                            n_id    = add_id(8'd0, w_b);
                            n_phase = PH_ID;
                        end else if (w_b == CH_PLUS) begin
                            n_pos   = 4'd1;
                            n_phase = PH_IPD;
                        end else begin
                            n_phase = PH_FAIL;
                        end
                    end
                    PH_OK: begin
                        n_phase = (w_b == CH_K) ? PH_OK_DONE : PH_FAIL;
                    end
                    PH_ID: begin
                        if (w_is_digit) begin
                            n_id = add_id(r_id, w_b);
                        end else if (w_b == CH_COMMA) begin
                            n_phase = PH_WORD;
                            n_pos   = 4'd0;
                            n_live  = 2'b11;
                        end else begin
                            n_phase = PH_FAIL;
                        end
                    end
                    PH_WORD: begin
                        if (r_pos >= 4'd7) begin
                            n_phase = PH_FAIL;
                        end else begin
                            if (r_live[0] && w_b != WORD_CONNECT[r_pos[2:0]]) n_live[0] = 1'b0;
                            if (r_live[1] && (r_pos >= 4'd6 ||
                                              w_b != WORD_CLOSED[r_pos[2:0]]))
                                n_live[1] = 1'b0;
                            n_pos = r_pos + 4'd1;
                            if (n_live[0] && n_pos == 4'd7) n_phase = PH_CONN_DONE;
                            else if (n_live[1] && n_pos == 4'd6) n_phase = PH_CLOSE_DONE;
                            else if (n_live == 2'b00) n_phase = PH_FAIL;
                        end
                    end
                    PH_IPD: begin
                        if (r_pos < 4'd5 && w_b == IPD_HEAD[r_pos[2:0]]) begin
                            n_pos = r_pos + 4'd1;
                            if (n_pos == 4'd5) begin
                                n_phase = PH_IPD_ID;
                                n_pos   = 4'd0;
                                n_id    = 8'd0;
                            end
                        end else begin
                            n_phase = PH_FAIL;
                        end
                    end
                    PH_IPD_ID: begin
                        if (w_is_digit) begin
                            n_id  = add_id(r_id, w_b);
                            n_pos = 4'd1;
                        end else if (w_b == CH_COMMA && r_pos != 4'd0) begin
                            n_phase = PH_IPD_LEN;
                            n_pos   = 4'd0;
                            n_len   = '0;
                        end else begin
                            n_phase = PH_FAIL;
                        end
                    end
                    PH_IPD_LEN: begin
                        if (w_is_digit) begin
                            n_len = add_len(r_len, w_b);
                            n_pos = 4'd1;
                        end else if (w_b == CH_COLON && r_pos != 4'd0 && r_len != '0) begin
                            n_rem   = r_len;
                            n_phase = PH_PAYLOAD;
                        end else begin
                            n_phase = PH_FAIL;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end

        // Verdict from the state after this byte
        w_verd.is_verdict = 1'b1;
        if (n_prompt) begin
            w_verd.verdict = VERDICT_PROMPT;
        end else if (n_phase == PH_OK_DONE) begin
            w_verd.verdict = VERDICT_OK;
        end else if (n_phase == PH_CONN_DONE) begin
            w_verd.verdict       = VERDICT_CONNECT;
            w_verd.client_number = n_id;
        end else if (n_phase == PH_CLOSE_DONE) begin
            w_verd.verdict       = VERDICT_CLOSED;
            w_verd.client_number = n_id;
        end else if (n_phase == PH_PAYLOAD || n_phase == PH_DATA_DONE) begin
            w_verd.verdict        = VERDICT_DATA;
            w_verd.client_number  = n_id;
            w_verd.payload_length = PAYLOAD_LEN_W'(n_len);
            w_verd.payload_short  = (n_phase == PH_PAYLOAD);
        end else begin
            w_verd.verdict = VERDICT_NONE;
        end

        if (w_last) begin
            n_phase  = PH_SKIP;
            n_id     = 8'd0;
            n_len    = '0;
            n_rem    = '0;
            n_prompt = 1'b0;
            n_pos    = 4'd0;
            n_live   = 2'b11;
            n_ended  = 1'b0;
        end

        w_res_a = w_has_pay ? w_pay : w_verd;
        w_res_b = w_verd;
        w_push  = w_accept ? (2'(w_has_pay) + 2'(w_last)) : 2'd0;

        n_head  = w_pop ? r_head + 2'd1 : r_head;
        n_tail  = r_tail + w_push;
        n_count = r_count + 3'(w_push) - 3'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SKIP;
            r_id     <= 8'd0;
            r_len    <= '0;
            r_rem    <= '0;
            r_prompt <= 1'b0;
            r_pos    <= 4'd0;
            r_live   <= 2'b11;
            r_ended  <= 1'b0;
            r_head   <= 2'd0;
            r_tail   <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (w_accept) begin
                r_phase  <= n_phase;
                r_id     <= n_id;
                r_len    <= n_len;
                r_rem    <= n_rem;
                r_prompt <= n_prompt;
                r_pos    <= n_pos;
                r_live   <= n_live;
                r_ended  <= n_ended;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
        if (w_push != 2'd0) r_q[r_tail] <= w_res_a;
        if (w_push == 2'd2) r_q[r_tail + 2'd1] <= w_res_b;
    end

    // Queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("output queue count out of range");

    // A final byte always leaves a verdict queued
    a_verdict_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_count != 3'd0))
        else $error("no result queued after final byte");

    // Parser is back at its start state after each buffer
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_phase == PH_SKIP && !r_prompt && !r_ended))
        else $error("parser not restarted after final byte");

    // Head and tail stay consistent with the fill count
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[1:0] == r_tail - r_head))
        else $error("queue pointers disagree with count");

endmodule

@@ dv/at_modem_response_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_modem_response_parser_tb
// Self-checking bench for the modem response parser. An initial block queues
// whole response buffers (a few directed ones, then random well-formed and
// broken responses). A falling-edge driver feeds them byte by byte, and a
// rising-edge monitor runs a parser model on every accepted byte. It also
// checks each result against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module at_modem_response_parser_tb;
    import atp_pkg::*;

    localparam int unsigned LEN_BITS       = 16;
    localparam int unsigned LEN_SAT        = (1 << LEN_BITS) - 1;
    localparam int unsigned ID_SAT         = 255;
    localparam int unsigned RANDOM_BYTES   = 1250;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned MAX_REPORTS    = 10;

    // ordering matters: everything below SCAN_PAYLOAD is an unfinished header
    typedef enum logic [3:0] {
        SCAN_SKIP, SCAN_OK, SCAN_ID, SCAN_WORD, SCAN_IPD, SCAN_IPD_ID,
        SCAN_IPD_LEN, SCAN_PAYLOAD, SCAN_OK_DONE, SCAN_CONN_DONE,
        SCAN_CLOSE_DONE, SCAN_FAIL, SCAN_DATA_DONE
    } t_scan;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    logic        in_taken = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned queued_bytes = 0;

    t_in_item   pending_bytes[$];
    t_out_item  expected_results[$];
    logic [7:0] scratch[$];

    // parser model state
    t_scan       scan_phase = SCAN_SKIP;
    logic [7:0]  link_id = '0;
    logic [15:0] ipd_length = '0;
    logic [15:0] data_left = '0;
    logic        prompt_seen = 1'b0;
    logic [3:0]  match_pos = '0;
    logic [1:0]  live_words = 2'b11;  // bit 0 CONNECT, bit 1 CLOSED
    logic        text_done = 1'b0;

    at_modem_response_parser #(
        .LENGTH_BITS(LEN_BITS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic logic is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic [7:0] id_push(logic [7:0] acc, logic [7:0] b);
        int unsigned v;
        v = int'(acc) * 10 + int'(b) - int'(CH_ZERO);
        return (v > ID_SAT) ? ID_SAT[7:0] : v[7:0];
    endfunction

    function automatic logic [15:0] len_push(logic [15:0] acc, logic [7:0] b);
        int unsigned v;
        v = int'(acc) * 10 + int'(b) - int'(CH_ZERO);
        return (v > LEN_SAT) ? LEN_SAT[15:0] : v[15:0];
    endfunction

    function automatic void restart_parser();
        scan_phase  = SCAN_SKIP;
        link_id     = '0;
        ipd_length  = '0;
        data_left   = '0;
        prompt_seen = 1'b0;
        match_pos   = '0;
        live_words  = 2'b11;
        text_done   = 1'b0;
    endfunction

    function automatic void scan_text(logic [7:0] b);
        case (scan_phase)
            SCAN_SKIP: begin
                if (b == CH_CR || b == CH_LF) begin
                end else if (b == CH_O) begin
                    scan_phase = SCAN_OK;
                end else if (is_digit(b)) begin
                    link_id = id_push(8'd0, b);
                    scan_phase = SCAN_ID;
                end else if (b == CH_PLUS) begin
                    match_pos = 4'd1;
                    scan_phase = SCAN_IPD;
                end else begin
                    scan_phase = SCAN_FAIL;
                end
            end
            SCAN_OK: begin
                scan_phase = (b == CH_K) ? SCAN_OK_DONE : SCAN_FAIL;
            end
            SCAN_ID: begin
                if (is_digit(b)) begin
                    link_id = id_push(link_id, b);
                end else if (b == CH_COMMA) begin
                    scan_phase = SCAN_WORD;
                    match_pos = '0;
                    live_words = 2'b11;
                end else begin
                    scan_phase = SCAN_FAIL;
                end
            end
            SCAN_WORD: begin
                if (match_pos >= 4'd7) begin
                    scan_phase = SCAN_FAIL;
                end else begin
                    if (live_words[0] && b != WORD_CONNECT[match_pos[2:0]])
                        live_words[0] = 1'b0;
                    if (live_words[1]) begin
                        if (match_pos >= 4'd6) live_words[1] = 1'b0;
                        else if (b != WORD_CLOSED[match_pos[2:0]]) live_words[1] = 1'b0;
                    end
                    match_pos = match_pos + 4'd1;
                    if (live_words[0] && match_pos == 4'd7) scan_phase = SCAN_CONN_DONE;
                    else if (live_words[1] && match_pos == 4'd6) scan_phase = SCAN_CLOSE_DONE;
                    else if (live_words == 2'b00) scan_phase = SCAN_FAIL;
                end
            end
            SCAN_IPD: begin
                if (match_pos < 4'd5 && b == IPD_HEAD[match_pos[2:0]]) begin
                    match_pos = match_pos + 4'd1;
                    if (match_pos == 4'd5) begin
                        scan_phase = SCAN_IPD_ID;
                        match_pos = '0;
                        link_id = '0;
                    end
                end else begin
                    scan_phase = SCAN_FAIL;
                end
            end
            SCAN_IPD_ID: begin
                if (is_digit(b)) begin
                    link_id = id_push(link_id, b);
                    match_pos = 4'd1;
                end else if (b == CH_COMMA && match_pos != 4'd0) begin
                    scan_phase = SCAN_IPD_LEN;
                    match_pos = '0;
                    ipd_length = '0;
                end else begin
                    scan_phase = SCAN_FAIL;
                end
            end
            SCAN_IPD_LEN: begin
                if (is_digit(b)) begin
                    ipd_length = len_push(ipd_length, b);
                    match_pos = 4'd1;
                end else if (b == CH_COLON && match_pos != 4'd0 && ipd_length != 16'd0) begin
                    data_left = ipd_length;
                    scan_phase = SCAN_PAYLOAD;
                end else begin
                    scan_phase = SCAN_FAIL;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void predict_results(t_in_item it);
        t_out_item r;
        if (scan_phase == SCAN_PAYLOAD) begin
            if (!text_done && it.byte_in == CH_GT) prompt_seen = 1'b1;
            if (it.byte_in == CH_NUL) text_done = 1'b1;
            r = '0;
            r.payload_byte = it.byte_in;
            expected_results.push_back(r);
            if (data_left != 16'd0) data_left = data_left - 16'd1;
            if (data_left == 16'd0) scan_phase = SCAN_DATA_DONE;
        end else if (!text_done) begin
            if (it.byte_in == CH_GT) prompt_seen = 1'b1;
            if (it.byte_in == CH_NUL) begin
                text_done = 1'b1;
                if (scan_phase < SCAN_PAYLOAD) scan_phase = SCAN_FAIL;
            end else begin
                scan_text(it.byte_in);
            end
        end
        if (it.end_of_buffer) begin
            r = '0;
            r.is_verdict = 1'b1;
            if (prompt_seen) begin
                r.verdict = VERDICT_PROMPT;
            end else if (scan_phase == SCAN_OK_DONE) begin
                r.verdict = VERDICT_OK;
            end else if (scan_phase == SCAN_CONN_DONE) begin
                r.verdict = VERDICT_CONNECT;
                r.client_number = link_id;
            end else if (scan_phase == SCAN_CLOSE_DONE) begin
                r.verdict = VERDICT_CLOSED;
                r.client_number = link_id;
            end else if (scan_phase == SCAN_PAYLOAD || scan_phase == SCAN_DATA_DONE) begin
                r.verdict = VERDICT_DATA;
                r.client_number = link_id;
                r.payload_length = ipd_length;
                r.payload_short = (scan_phase == SCAN_PAYLOAD);
            end else begin
                r.verdict = VERDICT_NONE;
            end
            expected_results.push_back(r);
            restart_parser();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Buffer generation
    // ------------------------------------------------------------------------
    function automatic logic [7:0] random_byte();
        logic [7:0] b;
        case ($urandom_range(11))
            0: b = CH_NUL;
            1: b = CH_GT;
            2: b = CH_CR;
            3: b = CH_LF;
            4: b = CH_COMMA;
            5: b = CH_COLON;
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) scratch.push_back(s[i]);
    endtask

    task automatic add_number(int unsigned value);
        if ($urandom_range(9) == 0) add_text("0");
        add_text($sformatf("%0d", value));
    endtask

    task automatic commit_buffer();
        t_in_item it;
        if (scratch.size() == 0) scratch.push_back(random_byte());
        foreach (scratch[i]) begin
            it.byte_in = scratch[i];
            it.end_of_buffer = (i == scratch.size() - 1);
            pending_bytes.push_back(it);
        end
        queued_bytes += scratch.size();
        scratch.delete();
    endtask

    task automatic make_random_response();
        int unsigned id_value;
        int unsigned len_value;
        int unsigned count;
        id_value = ($urandom_range(7) == 0) ? $urandom_range(99999, 256) : $urandom_range(255);
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) scratch.push_back($urandom_range(1) ? CH_CR : CH_LF);
        end
        case ($urandom_range(9))
            0: begin
                repeat ($urandom_range(8, 1)) scratch.push_back(random_byte());
            end
            1: begin
                add_text("OK");
                if ($urandom_range(1)) add_text("\r\n");
            end
            2, 3: begin
                add_number(id_value);
                add_text(",");
                if ($urandom_range(1)) add_text("CONNECT");
                else add_text("CLOSED");
                if ($urandom_range(1)) add_text("\r\n");
            end
            4: begin
                // prompt, sometimes hidden behind a zero byte
                if ($urandom_range(1)) add_text("OK\r\n");
                if ($urandom_range(2) == 0) scratch.push_back(CH_NUL);
                scratch.push_back(CH_GT);
                if ($urandom_range(1)) add_text(" ");
            end
            default: begin
                len_value = ($urandom_range(7) == 0) ? $urandom_range(999999, 65530)
                                                     : $urandom_range(8);
                add_text("+IPD,");
                add_number(id_value);
                add_text(",");
                add_number(len_value);
                add_text(":");
                count = (len_value > 8) ? $urandom_range(6) : len_value;
                case ($urandom_range(5))
                    0: count = (count > 0) ? $urandom_range(count - 1) : 0;  // short
                    1: count = count + $urandom_range(3, 1);                 // trailing bytes
                    default: begin
                    end
                endcase
                repeat (count) scratch.push_back(random_byte());
            end
        endcase
        // broken variants
        if (scratch.size() > 1 && $urandom_range(9) == 0)
            scratch.delete($urandom_range(scratch.size() - 1));
        if (scratch.size() > 0 && $urandom_range(9) == 0)
            scratch[$urandom_range(scratch.size() - 1)] = random_byte();
        if (scratch.size() > 0 && $urandom_range(11) == 0)
            scratch.insert($urandom_range(scratch.size() - 1), CH_NUL);
        if (scratch.size() > 1 && $urandom_range(11) == 0)
            repeat ($urandom_range(scratch.size() - 1)) void'(scratch.pop_back());
        commit_buffer();
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end else begin
            if (!in_valid || in_taken) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_data  <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall) predict_results(in_data);
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    note_error($sformatf("unexpected result: isv=%0d byte=%02h verdict=%0d",
                                         out_data.is_verdict, out_data.payload_byte,
                                         out_data.verdict));
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.is_verdict !== want.is_verdict
                        || out_data.payload_byte !== want.payload_byte
                        || out_data.verdict !== want.verdict
                        || out_data.client_number !== want.client_number
                        || out_data.payload_length !== want.payload_length
                        || out_data.payload_short !== want.payload_short) begin
                        note_error($sformatf({"mismatch: expected isv=%0d byte=%02h verdict=%0d ",
                                              "id=%0d len=%0d short=%0d, got isv=%0d byte=%02h ",
                                              "verdict=%0d id=%0d len=%0d short=%0d"},
                                             want.is_verdict, want.payload_byte, want.verdict,
                                             want.client_number, want.payload_length,
                                             want.payload_short, out_data.is_verdict,
                                             out_data.payload_byte, out_data.verdict,
                                             out_data.client_number, out_data.payload_length,
                                             out_data.payload_short));
                    end
                end
            end
        end
    end

    // watchdog: cycles without any transaction on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned start_count;

        // directed buffers
        scratch.push_back(CH_GT);
        commit_buffer();
        add_text("\n\r");
        commit_buffer();
        add_text("OK");
        commit_buffer();
        add_text("9,CONNECT");
        commit_buffer();
        add_text("+IPD,1,1:");
        scratch.push_back(8'hFF);   // payload byte on the final byte
        commit_buffer();
        scratch.push_back(CH_NUL);
        commit_buffer();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender pauses here until every verdict is back
        wait_drained();

        for (int stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 86;
                end
                1: begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 20;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            start_count = queued_bytes;
            while (queued_bytes - start_count < RANDOM_BYTES / 3) make_random_response();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
